// ----- hdl/lbc_pkg.sv -----
// lbc_pkg: request and status codes, controller states and the record types
// shared by the buffer cache controller, entry table and top level
// no dependencies
`default_nettype none

package lbc_pkg;

  localparam int unsigned DEV_W  = 8;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned SLOT_W = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GET_WR,
    S_SLOT_RD,
    S_SLOT_OP,
    S_SWEEP
  } state_e;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
  } tag_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] cnt;
  } meta_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctl_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              rd;
    status_e           status;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/lbc_table.sv -----
// lbc_table: entry table memory with one write and one registered read port
// entries never written read back as their reset contents; uses lbc_pkg
`default_nettype none

module lbc_table import lbc_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned IW          = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tbl_ctl_t      ctl_i,
  input  wire logic [IW-1:0] rd_addr_i,
  input  wire logic [IW-1:0] wr_addr_i,
  input  wire tag_t          wr_tag_i,
  input  wire meta_t         wr_meta_i,
  input  wire logic [IW-1:0] wr_rank_i,
  output tag_t               rd_tag_o,
  output meta_t              rd_meta_o,
  output logic [IW-1:0]      rd_rank_o
);

  tag_t          tag_mem  [NUM_BUFFERS];
  meta_t         meta_mem [NUM_BUFFERS];
  logic [IW-1:0] rank_mem [NUM_BUFFERS];

  logic [NUM_BUFFERS-1:0] written_q;

  tag_t          tag_rq;
  meta_t         meta_rq;
  logic [IW-1:0] rank_rq;
  logic [IW-1:0] idx_rq;
  logic          wrt_rq;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      tag_mem[wr_addr_i]  <= wr_tag_i;
      meta_mem[wr_addr_i] <= wr_meta_i;
      rank_mem[wr_addr_i] <= wr_rank_i;
    end
    if (ctl_i.rd_en) begin
      tag_rq  <= tag_mem[rd_addr_i];
      meta_rq <= meta_mem[rd_addr_i];
      rank_rq <= rank_mem[rd_addr_i];
      wrt_rq  <= written_q[rd_addr_i];
      idx_rq  <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (ctl_i.wr_en) begin
      written_q[wr_addr_i] <= 1'b1;
    end
  end

  // untouched entry: zero tag, not valid, no references, rank equal to its index
  always_comb begin
    if (wrt_rq) begin
      rd_tag_o  = tag_rq;
      rd_meta_o = meta_rq;
      rd_rank_o = rank_rq;
    end else begin
      rd_tag_o  = '0;
      rd_meta_o = '0;
      rd_rank_o = idx_rq;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lbc_ctrl.sv -----
// lbc_ctrl: request sequencer with the per-entry scan compare step
// walks the entry table one entry per cycle; uses lbc_pkg and drives lbc_table
`default_nettype none

module lbc_ctrl import lbc_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32,
  parameter int unsigned IW          = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [DEV_W-1:0]  device_id_i,
  input  wire logic [BLK_W-1:0]  block_number_i,
  input  wire logic [SLOT_W-1:0] buffer_slot_i,
  output logic                   busy_o,
  output tbl_ctl_t               ctl_o,
  output logic [IW-1:0]          rd_addr_o,
  output logic [IW-1:0]          wr_addr_o,
  output tag_t                   wr_tag_o,
  output meta_t                  wr_meta_o,
  output logic [IW-1:0]          wr_rank_o,
  input  wire tag_t              rd_tag_i,
  input  wire meta_t             rd_meta_i,
  input  wire logic [IW-1:0]     rd_rank_i,
  output res_t                   res_o
);

  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] CNT_END  = CW'(NUM_BUFFERS);
  localparam logic [IW-1:0] RANK_TOP = IW'(NUM_BUFFERS - 1);

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;

  req_e              req_q, req_d;
  tag_t              tag_q, tag_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic          mfound_q, mfound_d;
  logic [IW-1:0] midx_q, midx_d;
  meta_t         mmeta_q, mmeta_d;
  logic [IW-1:0] mrank_q, mrank_d;
  logic          ffound_q, ffound_d;
  logic [IW-1:0] fidx_q, fidx_d;
  logic [IW-1:0] frank_q, frank_d;
  logic [IW-1:0] rank_q, rank_d;

  logic [IW-1:0] sidx;
  logic [IW-1:0] pidx;
  logic          in_range;
  logic          match;
  logic [CNT_W-1:0] cnt_dec;

  assign sidx     = IW'(slot_q);
  assign pidx     = IW'(cnt_q - CW'(1));
  assign in_range = {{(32 - SLOT_W){1'b0}}, slot_q} < 32'(NUM_BUFFERS);
  assign match    = (rd_tag_i.dev == tag_q.dev) && (rd_tag_i.blk == tag_q.blk);
  assign cnt_dec  = rd_meta_i.cnt - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    req_q    <= req_d;
    tag_q    <= tag_d;
    slot_q   <= slot_d;
    mfound_q <= mfound_d;
    midx_q   <= midx_d;
    mmeta_q  <= mmeta_d;
    mrank_q  <= mrank_d;
    ffound_q <= ffound_d;
    fidx_q   <= fidx_d;
    frank_q  <= frank_d;
    rank_q   <= rank_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    req_d    = req_q;
    tag_d    = tag_q;
    slot_d   = slot_q;
    mfound_d = mfound_q;
    midx_d   = midx_q;
    mmeta_d  = mmeta_q;
    mrank_d  = mrank_q;
    ffound_d = ffound_q;
    fidx_d   = fidx_q;
    frank_d  = frank_q;
    rank_d   = rank_q;

    busy_o    = (state_q != S_IDLE);
    ctl_o     = '0;
    rd_addr_o = IW'(cnt_q);
    wr_addr_o = sidx;
    wr_tag_o  = rd_tag_i;
    wr_meta_o = rd_meta_i;
    wr_rank_o = rd_rank_i;
    res_o     = '0;
    res_o.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d    = req_e'(req_type_i);
          tag_d    = '{dev: device_id_i, blk: block_number_i};
          slot_d   = buffer_slot_i;
          cnt_d    = '0;
          mfound_d = 1'b0;
          ffound_d = 1'b0;
          state_d  = (req_e'(req_type_i) == REQ_GET) ? S_SCAN : S_SLOT_RD;
        end
      end

      // read entry cnt, compare entry cnt-1 that came back from the table
      S_SCAN: begin
        ctl_o.rd_en = (cnt_q != CNT_END);
        if (cnt_q != '0) begin
          if (match && (!mfound_q || rd_rank_i > mrank_q)) begin
            mfound_d = 1'b1;
            midx_d   = pidx;
            mmeta_d  = rd_meta_i;
            mrank_d  = rd_rank_i;
          end
          if ((rd_meta_i.cnt == '0) && (!ffound_q || rd_rank_i < frank_q)) begin
            ffound_d = 1'b1;
            fidx_d   = pidx;
            frank_d  = rd_rank_i;
          end
        end
        if (cnt_q == CNT_END) begin
          state_d = S_GET_WR;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      S_GET_WR: begin
        res_o.vld = 1'b1;
        wr_tag_o  = tag_q;
        if (mfound_q) begin
          res_o.slot = SLOT_W'(midx_q);
          res_o.hit  = 1'b1;
          if (mmeta_q.cnt == COUNT_MAX) begin
            res_o.status = ST_OVERFLOW;
          end else begin
            ctl_o.wr_en = 1'b1;
            wr_addr_o   = midx_q;
            wr_meta_o   = '{valid: 1'b1, cnt: mmeta_q.cnt + CNT_W'(1)};
            wr_rank_o   = mrank_q;
            res_o.rd    = !mmeta_q.valid;
          end
        end else if (ffound_q) begin
          ctl_o.wr_en = 1'b1;
          wr_addr_o   = fidx_q;
          wr_meta_o   = '{valid: 1'b1, cnt: CNT_W'(1)};
          wr_rank_o   = frank_q;
          res_o.slot  = SLOT_W'(fidx_q);
          res_o.rd    = 1'b1;
        end else begin
          res_o.status = ST_NO_FREE;
        end
        state_d = S_IDLE;
      end

      S_SLOT_RD: begin
        ctl_o.rd_en = in_range;
        rd_addr_o   = sidx;
        state_d     = S_SLOT_OP;
      end

      S_SLOT_OP: begin
        res_o.slot = slot_q;
        state_d    = S_IDLE;
        if (in_range) begin
          case (req_q)
            REQ_PIN: begin
              if (rd_meta_i.cnt == COUNT_MAX) begin
                res_o.status = ST_OVERFLOW;
              end else begin
                ctl_o.wr_en   = 1'b1;
                wr_meta_o.cnt = rd_meta_i.cnt + CNT_W'(1);
              end
            end
            REQ_RELEASE, REQ_UNPIN: begin
              if (rd_meta_i.cnt == '0) begin
                res_o.status = ST_UNDERFLOW;
              end else if ((req_q == REQ_RELEASE) && (cnt_dec == '0)) begin
                // last reference dropped: reorder ranks, the entry itself
                // is written during the sweep
                rank_d  = rd_rank_i;
                cnt_d   = '0;
                state_d = S_SWEEP;
              end else begin
                ctl_o.wr_en   = 1'b1;
                wr_meta_o.cnt = cnt_dec;
              end
            end
            default: begin
            end
          endcase
        end
        res_o.vld = (state_d == S_IDLE);
      end

      // entries above the released rank step down, released entry goes on top
      S_SWEEP: begin
        ctl_o.rd_en = (cnt_q != CNT_END);
        wr_addr_o   = pidx;
        if (cnt_q != '0) begin
          if (pidx == sidx) begin
            ctl_o.wr_en   = 1'b1;
            wr_meta_o.cnt = '0;
            wr_rank_o     = RANK_TOP;
          end else if (rd_rank_i > rank_q) begin
            ctl_o.wr_en = 1'b1;
            wr_rank_o   = rd_rank_i - IW'(1);
          end
        end
        if (cnt_q == CNT_END) begin
          res_o.vld  = 1'b1;
          res_o.slot = slot_q;
          state_d    = S_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/lru_block_buffer_cache.sv -----
// Buffer cache with reference counts and least-recently-used replacement.
// An item is taken when start is high and busy is low; its result shows on
// the result ports for exactly one cycle with done_o high, and cannot be held
// off. A get walks the whole entry table through its single read port, one
// entry per cycle, before it answers; a release that drops the last reference
// walks the whole table to reorder ranks before it answers; pin, unpin and
// other releases read and update only their own slot. busy falls in the cycle
// the result appears, so the next item may be taken at the edge ending it.
// No clearing pass is needed after reset.
// depends on lbc_pkg, lbc_ctrl and lbc_table
`default_nettype none

module lru_block_buffer_cache import lbc_pkg::*; #(
  parameter int unsigned NUM_BUFFERS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [DEV_W-1:0]  device_id_i,
  input  wire logic [BLK_W-1:0]  block_number_i,
  input  wire logic [SLOT_W-1:0] buffer_slot_i,
  output logic                   done_o,
  output logic [SLOT_W-1:0]      slot_out_o,
  output logic                   was_hit_o,
  output logic                   needs_read_o,
  output logic [1:0]             status_o
);

  localparam int unsigned IW = $clog2(NUM_BUFFERS);

  tbl_ctl_t      ctl;
  logic [IW-1:0] rd_addr, wr_addr, wr_rank, rd_rank;
  tag_t          wr_tag, rd_tag;
  meta_t         wr_meta, rd_meta;
  res_t          res;

  logic              vld_q;
  logic [SLOT_W-1:0] slot_q;
  logic              hit_q;
  logic              rd_q;
  status_e           status_q;

  lbc_ctrl #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .IW         (IW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .req_type_i    (req_type_i),
    .device_id_i   (device_id_i),
    .block_number_i(block_number_i),
    .buffer_slot_i (buffer_slot_i),
    .busy_o        (busy),
    .ctl_o         (ctl),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .wr_tag_o      (wr_tag),
    .wr_meta_o     (wr_meta),
    .wr_rank_o     (wr_rank),
    .rd_tag_i      (rd_tag),
    .rd_meta_i     (rd_meta),
    .rd_rank_i     (rd_rank),
    .res_o         (res)
  );

  lbc_table #(
    .NUM_BUFFERS(NUM_BUFFERS),
    .IW         (IW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .rd_addr_i(rd_addr),
    .wr_addr_i(wr_addr),
    .wr_tag_i (wr_tag),
    .wr_meta_i(wr_meta),
    .wr_rank_i(wr_rank),
    .rd_tag_o (rd_tag),
    .rd_meta_o(rd_meta),
    .rd_rank_o(rd_rank)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld) begin
      slot_q   <= res.slot;
      hit_q    <= res.hit;
      rd_q     <= res.rd;
      status_q <= res.status;
    end
  end

  assign done_o       = vld_q;
  assign slot_out_o   = slot_q;
  assign was_hit_o    = hit_q;
  assign needs_read_o = rd_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ----- hdl/lbc_checker.sv -----
// lbc_checker: port-level checks on the buffer cache handshake and results
// bound to lru_block_buffer_cache; uses lbc_pkg
`default_nettype none

module lbc_checker import lbc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done_o,
  input wire logic [SLOT_W-1:0] slot_out_o,
  input wire logic              was_hit_o,
  input wire logic              needs_read_o,
  input wire logic [1:0]        status_o
);

  // a taken item raises busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after item taken");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_NO_FREE) |->
      (slot_out_o == '0) && !was_hit_o && !needs_read_o)
    else $error("no free result carries data");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && needs_read_o |-> (status_o == ST_OK))
    else $error("disk read flagged on a failed request");

endmodule

bind lru_block_buffer_cache lbc_checker u_lbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .slot_out_o  (slot_out_o),
  .was_hit_o   (was_hit_o),
  .needs_read_o(needs_read_o),
  .status_o    (status_o)
);

`default_nettype wire
